// ----- design/isort_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_pkg
// Shared constants, types and command/status structs of the insertion sorter.
// ----------------------------------------------------------------------------
package isort_pkg;

   localparam int CAPACITY    = 64;
   localparam int VALUE_WIDTH = 16;
   localparam int IO_WIDTH    = 16;
   localparam int ADDR_WIDTH  = $clog2(CAPACITY);
   localparam int FILL_WIDTH  = $clog2(CAPACITY + 1);

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [ADDR_WIDTH-1:0]  addr_type;
   typedef logic [FILL_WIDTH-1:0]  fill_type;
   typedef logic [IO_WIDTH-1:0]    io_type;

   typedef enum logic [1:0] {
      RD_FILL = 2'd0,
      RD_DOWN = 2'd1,
      RD_ZERO = 2'd2,
      RD_UP   = 2'd3
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_IN_ZERO  = 2'd0,
      WR_DATA_UP  = 2'd1,
      WR_VAL_UP   = 2'd2,
      WR_VAL_ZERO = 2'd3
   } wr_sel_type;

   typedef enum logic [2:0] {
      IDX_HOLD = 3'd0,
      IDX_FILL = 3'd1,
      IDX_DOWN = 3'd2,
      IDX_ZERO = 3'd3,
      IDX_UP   = 3'd4
   } idx_sel_type;

   typedef struct packed {
      logic        load;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_sel_type  wr_sel;
      idx_sel_type idx_sel;
      logic        fill_inc;
      logic        ovf_set;
      logic        clear;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic last;
      logic shift;
      logic idx_zero;
      logic emit_last;
   } status_type;

   function automatic value_type to_store(io_type x);
      return VALUE_WIDTH'($signed(x));
   endfunction

   function automatic io_type to_io(value_type x);
      return IO_WIDTH'($signed(x));
   endfunction

endpackage

// ----- design/isort_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_ctrl
// Sequencer of the insertion sorter: scan/shift per insert, then emit batch.
// ----------------------------------------------------------------------------
module isort_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                batch_end,
   input  isort_pkg::status_type status,
   output isort_pkg::cmd_type  cmd,
   output logic                busy
);
   import isort_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE       = 5'b00001,
      ST_SCAN       = 5'b00010,
      ST_PLACE      = 5'b00100,
      ST_EMIT_FETCH = 5'b01000,
      ST_EMIT       = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.rd_sel   = RD_FILL;
      cmd.wr_sel   = WR_IN_ZERO;
      cmd.idx_sel  = IDX_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               priority if (status.full) begin
                  cmd.ovf_set = 1'b1;
                  if (batch_end) state_in = ST_EMIT_FETCH;
               end else if (status.empty) begin
                  cmd.wr_en    = 1'b1;
                  cmd.wr_sel   = WR_IN_ZERO;
                  cmd.fill_inc = 1'b1;
                  if (batch_end) state_in = ST_EMIT_FETCH;
               end else begin
                  cmd.rd_sel  = RD_FILL;
                  cmd.idx_sel = IDX_FILL;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.wr_en = 1'b1;
            if (status.shift) begin
               cmd.wr_sel = WR_DATA_UP;
               if (status.idx_zero) begin
                  state_in = ST_PLACE;
               end else begin
                  cmd.idx_sel = IDX_DOWN;
                  cmd.rd_sel  = RD_DOWN;
               end
            end else begin
               cmd.wr_sel   = WR_VAL_UP;
               cmd.fill_inc = 1'b1;
               state_in     = status.last ? ST_EMIT_FETCH : ST_IDLE;
            end
         end
         ST_PLACE: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = WR_VAL_ZERO;
            cmd.fill_inc = 1'b1;
            state_in     = status.last ? ST_EMIT_FETCH : ST_IDLE;
         end
         ST_EMIT_FETCH: begin
            cmd.rd_sel  = RD_ZERO;
            cmd.idx_sel = IDX_ZERO;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_last) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cmd.rd_sel  = RD_UP;
               cmd.idx_sel = IDX_UP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   ast_emit_only_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> busy)
      else $error("emit while idle");

   ast_place_after_shift: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PLACE) |-> $past(state_ff == ST_SCAN && status.shift && status.idx_zero))
      else $error("place without shift to bottom");

   ast_scan_not_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !status.full)
      else $error("scan with full store");

endmodule

// ----- design/isort_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_dpath
// Sorted store memory, scan index, fill count and overflow flag.
// ----------------------------------------------------------------------------
module isort_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  isort_pkg::cmd_type    cmd,
   input  isort_pkg::io_type     item_value,
   input  logic                  batch_end,
   output isort_pkg::status_type status,
   output isort_pkg::io_type     sorted_value,
   output logic                  run_end,
   output logic                  dropped_flag
);
   import isort_pkg::*;

   value_type mem [CAPACITY];
   value_type rd_data_ff;
   value_type val_ff;
   logic      last_ff;
   fill_type  fill_ff, fill_in;
   logic      ovf_ff, ovf_in;
   addr_type  idx_ff, idx_in;
   addr_type  rd_addr, wr_addr;
   value_type wr_data;
   addr_type  fill_top;

   assign fill_top = addr_type'(fill_ff - fill_type'(1));

   always_comb begin
      unique case (cmd.rd_sel)
         RD_FILL: rd_addr = fill_top;
         RD_DOWN: rd_addr = idx_ff - addr_type'(1);
         RD_ZERO: rd_addr = '0;
         RD_UP:   rd_addr = idx_ff + addr_type'(1);
         default: rd_addr = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.wr_sel)
         WR_IN_ZERO: begin
            wr_addr = '0;
            wr_data = to_store(item_value);
         end
         WR_DATA_UP: begin
            wr_addr = idx_ff + addr_type'(1);
            wr_data = rd_data_ff;
         end
         WR_VAL_UP: begin
            wr_addr = idx_ff + addr_type'(1);
            wr_data = val_ff;
         end
         WR_VAL_ZERO: begin
            wr_addr = '0;
            wr_data = val_ff;
         end
         default: begin
            wr_addr = '0;
            wr_data = val_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      unique case (cmd.idx_sel)
         IDX_HOLD: idx_in = idx_ff;
         IDX_FILL: idx_in = fill_top;
         IDX_DOWN: idx_in = idx_ff - addr_type'(1);
         IDX_ZERO: idx_in = '0;
         IDX_UP:   idx_in = idx_ff + addr_type'(1);
         default:  idx_in = idx_ff;
      endcase
   end

   always_comb begin
      fill_in = fill_ff;
      ovf_in  = ovf_ff;
      if (cmd.clear) begin
         fill_in = '0;
         ovf_in  = 1'b0;
      end else begin
         if (cmd.fill_inc) fill_in = fill_ff + fill_type'(1);
         if (cmd.ovf_set)  ovf_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         ovf_ff  <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) begin
         val_ff  <= to_store(item_value);
         last_ff <= batch_end;
      end
   end

   assign status.full      = (fill_ff == fill_type'(CAPACITY));
   assign status.empty     = (fill_ff == '0);
   assign status.last      = last_ff;
   assign status.shift     = ($signed(rd_data_ff) >= $signed(val_ff));
   assign status.idx_zero  = (idx_ff == '0);
   assign status.emit_last = ({1'b0, idx_ff} == (fill_ff - fill_type'(1)));

   assign sorted_value = to_io(rd_data_ff);
   assign run_end      = cmd.emit & status.emit_last;
   assign dropped_flag = ovf_ff;

   ast_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= fill_type'(CAPACITY))
      else $error("fill count beyond capacity");

   ast_inc_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_inc |-> !status.full)
      else $error("insert into full store");

   ast_clear_after_run: assert property (@(posedge clock) disable iff (reset)
      run_end |=> (fill_ff == '0) && !ovf_ff)
      else $error("store not emptied after batch");

   ast_emit_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !status.empty)
      else $error("emit from empty store");

endmodule

// ----- design/insertion_sorter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sorter
// Batch insertion sort into a bounded ascending store, emitted on batch end.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a transaction is taken at a clock edge with start high and busy
//   low; req_item_value is inserted in front of the first stored value that
//   is not smaller. req_batch_end marks the last value of a batch.
//   Insert: into an empty or full store there is no scan (busy stays low unless
//   the batch ends); otherwise a scan/shift loop over the store memory moves
//   up every stored value not smaller than the new one, then places it.
//   Output: after the batch-end insert, a fetch state, then one result
//   per cycle in ascending order, rsp_valid high for each. rsp_run_end marks
//   the final one; rsp_dropped_flag is high on all results of a batch that
//   lost values beyond the 64-entry capacity. busy stays high until done.
//   The receiver cannot stall; each result is shown for one cycle only.
//   Reset empties the store and clears the overflow flag; store contents
//   need no clearing.
// ----------------------------------------------------------------------------
module insertion_sorter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic signed [15:0]    req_item_value,
   input  logic                  req_batch_end,
   output logic                  rsp_valid,
   output logic signed [15:0]    rsp_sorted_value,
   output logic                  rsp_run_end,
   output logic                  rsp_dropped_flag
);
   import isort_pkg::*;

   cmd_type    cmd;
   status_type status;
   io_type     sorted_value;

   isort_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .batch_end (req_batch_end),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   isort_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .item_value   (io_type'(req_item_value)),
      .batch_end    (req_batch_end),
      .status       (status),
      .sorted_value (sorted_value),
      .run_end      (rsp_run_end),
      .dropped_flag (rsp_dropped_flag)
   );

   assign rsp_valid        = cmd.emit;
   assign rsp_sorted_value = $signed(sorted_value);

endmodule
